// ===== rtl/htlin_pkg.sv =====
// Shared constants for the humidity and temperature linearization block.
`default_nettype none

package htlin_pkg;

  // Coefficient format
  localparam int unsigned COEF_FRAC_BITS_DEF = 32;
  localparam int unsigned COEF_W             = 48;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TEMP_OFFSET = 3'd0;
  localparam logic [2:0] REG_TEMP_SLOPE  = 3'd1;
  localparam logic [2:0] REG_HUM_CONST   = 3'd2;
  localparam logic [2:0] REG_HUM_LINEAR  = 3'd3;
  localparam logic [2:0] REG_HUM_SQUARE  = 3'd4;
  localparam logic [2:0] REG_COMP_CONST  = 3'd5;
  localparam logic [2:0] REG_COMP_LINEAR = 3'd6;

  // Reset coefficients, scaled for 32 fraction bits
  localparam logic signed [47:0] RST_TEMP_OFFSET = -48'sd170510201651;
  localparam logic signed [47:0] RST_TEMP_SLOPE  =  48'sd42949673;
  localparam logic signed [47:0] RST_HUM_CONST   = -48'sd8790939061;
  localparam logic signed [47:0] RST_HUM_LINEAR  =  48'sd157625300;
  localparam logic signed [47:0] RST_HUM_SQUARE  = -48'sd6853;
  localparam logic signed [47:0] RST_COMP_CONST  =  48'sd42949673;
  localparam logic signed [47:0] RST_COMP_LINEAR =  48'sd343597;

  // Output limits in hundredths
  localparam logic signed [14:0] TEMP_MIN  = -15'sd3990;
  localparam logic signed [14:0] TEMP_MAX  =  15'sd12000;
  localparam logic signed [14:0] TEMP_BIAS =  15'sd4100;
  localparam logic [13:0]        HUM_MIN   =  14'd10;
  localparam logic [13:0]        HUM_MAX   =  14'd10000;

endpackage

`default_nettype wire

// ===== rtl/humidity_temperature_linearize.sv =====
// Top level: pipelined conversion of raw sensor counts to temperature and humidity.
//
// Converts one pair of raw temperature and humidity counts per clock, unless the output
// stalls, into calibrated temperature and relative humidity in hundredths, using seven
// signed coefficient registers in Q(48-F).F format written over the APB port (8-byte
// spacing). The datapath is a seven-stage pipeline: it accepts one transfer every cycle
// when the output side does not stall, and holds each result in the output register of
// the last stage. The pipeline depth is set by the temperature-compensation product, a
// 64 x 64 bit exact multiply cut into four partial products of 32-bit halves in one
// stage and summed in the next. Empty stages close up under backpressure, so a stalled
// output holds its result while upstream stages keep filling.
`default_nettype none

module humidity_temperature_linearize
  import htlin_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [13:0] raw_temperature, [25:14] raw_humidity
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int unsigned NSTG = 7;
  localparam int unsigned F    = COEF_FRAC_BITS;
  localparam int unsigned TDW  = F + 8;       // clamped temperature above lower limit
  localparam int unsigned TDDW = F + 15;      // same times 100
  localparam int unsigned HYW  = 2 * F + 14;  // humidity times 100, low bits kept

  localparam logic signed [63:0]  T_LO  = -(64'sd41 <<< F);
  localparam logic signed [63:0]  T_HI  =  (64'sd121 <<< F);
  localparam logic signed [63:0]  T_MID =  (64'sd25 <<< F);
  localparam logic signed [127:0] H_LIM =  (128'sd101 <<< (2 * F));

  // Configuration registers
  logic signed [47:0] temp_offset, temp_slope, hum_const, hum_linear;
  logic signed [47:0] hum_square, comp_const, comp_linear;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_offset <= RST_TEMP_OFFSET;
      temp_slope  <= RST_TEMP_SLOPE;
      hum_const   <= RST_HUM_CONST;
      hum_linear  <= RST_HUM_LINEAR;
      hum_square  <= RST_HUM_SQUARE;
      comp_const  <= RST_COMP_CONST;
      comp_linear <= RST_COMP_LINEAR;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_TEMP_OFFSET: temp_offset <= pwdata[47:0];
        REG_TEMP_SLOPE:  temp_slope  <= pwdata[47:0];
        REG_HUM_CONST:   hum_const   <= pwdata[47:0];
        REG_HUM_LINEAR:  hum_linear  <= pwdata[47:0];
        REG_HUM_SQUARE:  hum_square  <= pwdata[47:0];
        REG_COMP_CONST:  comp_const  <= pwdata[47:0];
        REG_COMP_LINEAR: comp_linear <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read back, sign extended
  always_comb begin
    case (paddr[5:3])
      REG_TEMP_OFFSET: prdata = 64'(temp_offset);
      REG_TEMP_SLOPE:  prdata = 64'(temp_slope);
      REG_HUM_CONST:   prdata = 64'(hum_const);
      REG_HUM_LINEAR:  prdata = 64'(hum_linear);
      REG_HUM_SQUARE:  prdata = 64'(hum_square);
      REG_COMP_CONST:  prdata = 64'(comp_const);
      REG_COMP_LINEAR: prdata = 64'(comp_linear);
      default:         prdata = '0;
    endcase
  end

  // Stage flow control: a stage advances when it is empty or the next one advances
  logic [NSTG:1] vld;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k + 1];
    end
  end

  assign s_axis_tready = adv[1];
  assign m_axis_tvalid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  // Stage 1: products with the raw counts
  logic [13:0]        raw_t;
  logic [11:0]        raw_h;
  logic signed [61:0] s1_pt;
  logic signed [59:0] s1_pc, s1_pl;
  logic [23:0]        s1_rh2;

  assign raw_t = s_axis_tdata[13:0];
  assign raw_h = s_axis_tdata[25:14];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_pt  <= 62'(temp_slope) * 62'($signed({1'b0, raw_t}));
      s1_pc  <= 60'(comp_linear) * 60'($signed({1'b0, raw_h}));
      s1_pl  <= 60'(hum_linear) * 60'($signed({1'b0, raw_h}));
      s1_rh2 <= 24'(raw_h) * 24'(raw_h);
    end
  end

  // Stage 2: temperature, offset from 25 degrees, compensation factor, linear and square terms
  logic signed [62:0] s2_tq;
  logic signed [63:0] s2_dt, s2_comp;
  logic signed [60:0] s2_lin1;
  logic [47:0]        s2_sql;
  logic signed [48:0] s2_sqh;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_tq   <= 63'(temp_offset) + 63'(s1_pt);
      s2_dt   <= 64'(temp_offset) + 64'(s1_pt) - T_MID;
      s2_comp <= 64'(comp_const) + 64'(s1_pc);
      s2_lin1 <= 61'(hum_const) + 61'(s1_pl);
      s2_sql  <= 48'(hum_square[23:0]) * 48'(s1_rh2);
      s2_sqh  <= 49'($signed(hum_square[47:24])) * 49'($signed({1'b0, s1_rh2}));
    end
  end

  // Stage 3: partial products of the compensation, linear humidity, temperature clamp
  logic signed [63:0] tq_ext, tc, td_full;
  logic signed [72:0] lin_full;
  logic [63:0]        s3_pll;
  logic signed [64:0] s3_phl, s3_plh;
  logic signed [63:0] s3_phh;
  logic signed [72:0] s3_lin;
  logic [TDW-1:0]     s3_td;

  always_comb begin
    tq_ext = 64'(s2_tq);
    if (tq_ext < T_LO) begin
      tc = T_LO;
    end else if (tq_ext > T_HI) begin
      tc = T_HI;
    end else begin
      tc = tq_ext;
    end
    td_full  = tc - T_LO;
    lin_full = 73'(s2_lin1) + (73'(s2_sqh) <<< 24) + $signed({25'd0, s2_sql});
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_pll <= 64'(s2_dt[31:0]) * 64'(s2_comp[31:0]);
      s3_phl <= 65'($signed(s2_dt[63:32])) * 65'($signed({1'b0, s2_comp[31:0]}));
      s3_plh <= 65'($signed({1'b0, s2_dt[31:0]})) * 65'($signed(s2_comp[63:32]));
      s3_phh <= 64'($signed(s2_dt[63:32])) * 64'($signed(s2_comp[63:32]));
      s3_lin <= lin_full;
      s3_td  <= td_full[TDW-1:0];
    end
  end

  // Stage 4: sum partial products, scale temperature by 100
  logic signed [127:0] s4_prod;
  logic signed [72:0]  s4_lin;
  logic [TDDW-1:0]     s4_tdd;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_prod <= $signed({64'd0, s3_pll}) + (128'(s3_phl) <<< 32)
               + (128'(s3_plh) <<< 32) + (128'(s3_phh) <<< 64);
      s4_lin  <= s3_lin;
      s4_tdd  <= (TDDW'(s3_td) << 6) + (TDDW'(s3_td) << 5) + (TDDW'(s3_td) << 2);
    end
  end

  // Stage 5: true humidity in Q.2F, temperature output
  logic signed [14:0] t_val, t_out;
  logic signed [127:0] s5_x;
  logic signed [14:0]  s5_tout;

  always_comb begin
    t_val = $signed({1'b0, s4_tdd[F +: 14]}) - TEMP_BIAS;
    if (t_val < TEMP_MIN) begin
      t_out = TEMP_MIN;
    end else if (t_val > TEMP_MAX) begin
      t_out = TEMP_MAX;
    end else begin
      t_out = t_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_x    <= s4_prod + (128'(s4_lin) <<< F);
      s5_tout <= t_out;
    end
  end

  // Stage 6: range flags and humidity times 100
  logic [HYW-1:0]     x_lo;
  logic               s6_neg, s6_big;
  logic [HYW-1:0]     s6_y;
  logic signed [14:0] s6_tout;

  assign x_lo = s5_x[HYW-1:0];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_neg  <= s5_x[127];
      s6_big  <= s5_x >= H_LIM;
      s6_y    <= (x_lo << 6) + (x_lo << 5) + (x_lo << 2);
      s6_tout <= s5_tout;
    end
  end

  // Stage 7: humidity clamp, output register
  logic [13:0]        h_raw, h_out;
  logic [13:0]        s7_hum;
  logic signed [14:0] s7_tout;

  assign h_raw = s6_y[HYW-1 -: 14];

  always_comb begin
    priority if (s6_neg) begin
      h_out = HUM_MIN;
    end else if (s6_big) begin
      h_out = HUM_MAX;
    end else if (h_raw < HUM_MIN) begin
      h_out = HUM_MIN;
    end else if (h_raw > HUM_MAX) begin
      h_out = HUM_MAX;
    end else begin
      h_out = h_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_hum  <= h_out;
      s7_tout <= s6_tout;
    end
  end

  assign m_axis_tdata = {3'd0, s7_hum, s7_tout};

endmodule

`default_nettype wire

// ===== rtl/htlin_chk.sv =====
// Port-level checker for the linearization block, bound to its top level.
`default_nettype none

module htlin_chk
  import htlin_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transfer dropped or changed while stalled");

  // Clear the pipeline on reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Take input whenever the output register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Keep results inside the clamp limits
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= TEMP_MIN)
      && ($signed(m_axis_tdata[14:0]) <= TEMP_MAX)
      && (m_axis_tdata[28:15] >= HUM_MIN) && (m_axis_tdata[28:15] <= HUM_MAX))
    else $error("result outside clamp limits");

endmodule

bind humidity_temperature_linearize htlin_chk u_htlin_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
